/* src/vbs_pkg.sv */
// shared types and constants for the vertex bone skinning block
`timescale 1ns / 1ps
`default_nettype none
package vbs_pkg;

  localparam int MAX_BONES_DEF       = 64;
  localparam int MAX_GROUPS_DEF      = 64;
  localparam int SLOTS_PER_GROUP_DEF = 4;
  localparam int FRAC_BITS_DEF       = 16;
  localparam int MAT_WORDS           = 12;

  typedef enum logic [1:0] {
    OP_MAT  = 2'd0,
    OP_SLOT = 2'd1,
    OP_HDR  = 2'd2,
    OP_SKIN = 2'd3
  } op_t;

  typedef struct packed {
    op_t                operation;
    logic [5:0]         index;
    logic [3:0]         element;
    logic               flag;
    logic signed [31:0] value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] nrm_x;
    logic signed [31:0] nrm_y;
    logic signed [31:0] nrm_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_nrm_x;
    logic signed [31:0] out_nrm_y;
    logic signed [31:0] out_nrm_z;
    logic               status;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic clr_step;
    logic slot_rd;
    logic slot_next;
    logic mat_rd;
    logic div_start;
    logic div_step;
    logic div_fin;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic pass;
    logic slot_more;
    logic slot_filled;
    logic mat_last;
    logic div_done;
  } sts_t;

endpackage
`default_nettype wire

/* src/vbs_ctrl.sv */
// sequencing state machine of the skinning block
`timescale 1ns / 1ps
`default_nettype none
module vbs_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  vbs_pkg::op_t     operation,
  output logic             busy,
  output vbs_pkg::cmd_t    cmd,
  input  vbs_pkg::sts_t    sts
);
  import vbs_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HDR, S_SRD, S_SCHK, S_MAT, S_DRAIN, S_DSTART, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] drn_r, drn_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    drn_nxt   = drn_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.accept = start;
        if (start && operation == OP_SKIN) state_nxt = S_HDR;
      end
      S_HDR: begin
        state_nxt = sts.pass ? S_OUT : S_SRD;
      end
      S_SRD: begin
        drn_nxt = '0;
        if (sts.slot_more) begin
          cmd.slot_rd = 1'b1;
          state_nxt   = S_SCHK;
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_SCHK: begin
        if (sts.slot_filled) begin
          state_nxt = S_MAT;
        end else begin
          cmd.slot_next = 1'b1;
          state_nxt     = S_SRD;
        end
      end
      S_MAT: begin
        cmd.mat_rd = 1'b1;
        if (sts.mat_last) begin
          cmd.slot_next = 1'b1;
          state_nxt     = S_SRD;
        end
      end
      S_DRAIN: begin
        // let the multiply pipeline empty into the accumulators
        drn_nxt = drn_r + 2'd1;
        if (drn_r == 2'd2) state_nxt = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_FIN;
        else cmd.div_step = 1'b1;
      end
      S_FIN: begin
        cmd.div_fin = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        cmd.out_load = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      drn_r   <= '0;
    end else begin
      state_r <= state_nxt;
      drn_r   <= drn_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/vbs_dp.sv */
// tables, multiply-accumulate pipeline and bit-serial dividers of the skinning block
`timescale 1ns / 1ps
`default_nettype none
module vbs_dp #(
  parameter int MAX_BONES       = vbs_pkg::MAX_BONES_DEF,
  parameter int MAX_GROUPS      = vbs_pkg::MAX_GROUPS_DEF,
  parameter int SLOTS_PER_GROUP = vbs_pkg::SLOTS_PER_GROUP_DEF,
  parameter int FRAC_BITS       = vbs_pkg::FRAC_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  vbs_pkg::in_item_t   in_item,
  input  vbs_pkg::cmd_t       cmd,
  output vbs_pkg::sts_t       sts,
  output vbs_pkg::out_item_t  out_item,
  output logic                out_valid
);
  import vbs_pkg::*;

  localparam int BW         = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam int GW         = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int SLOT_DEPTH = MAX_GROUPS * SLOTS_PER_GROUP;
  localparam int SA_W       = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int MAT_DEPTH  = MAX_BONES * MAT_WORDS;
  localparam int MA_W       = $clog2(MAT_DEPTH);
  localparam int CW         = $clog2(SLOTS_PER_GROUP + 1);
  localparam int ACC_W      = 69 - FRAC_BITS;
  localparam int DC_W       = $clog2(ACC_W + 1);

  localparam logic signed [ACC_W:0] SAT_MAX = (ACC_W + 1)'(32'sh7fffffff);
  localparam logic signed [ACC_W:0] SAT_MIN = (ACC_W + 1)'($signed(32'h80000000));

  typedef struct packed {
    logic          filled;
    logic [BW-1:0] bone;
  } slot_ent_t;

  typedef struct packed {
    logic          present;
    logic [CW-1:0] count;
  } hdr_ent_t;

  function automatic logic signed [31:0] sat_acc(input logic signed [ACC_W:0] v);
    if (v > SAT_MAX) return 32'sh7fffffff;
    if (v < SAT_MIN) return $signed(32'h80000000);
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) return v[32] ? $signed(32'h80000000) : 32'sh7fffffff;
    return v[31:0];
  endfunction

  logic signed [31:0] mat_mem [MAT_DEPTH];
  slot_ent_t          slot_mem [SLOT_DEPTH];
  hdr_ent_t           hdr_mem [MAX_GROUPS];

  logic signed [31:0] mat_q;
  slot_ent_t          slot_q;
  hdr_ent_t           hdr_q;

  logic [SA_W-1:0]    clr_cnt_r;
  logic [GW-1:0]      grp_r;
  logic               grp_ok_r;
  logic [CW-1:0]      j_r;
  logic [3:0]         e_r;
  logic [1:0]         row_r, col_r;

  logic signed [31:0] pos_r [3];
  logic signed [31:0] nrm_r [3];
  logic signed [31:0] tgt_r [3];

  logic               s1_v_r, s2_v_r;
  logic [1:0]         s1_row_r, s1_col_r, s2_col_r;
  logic signed [ACC_W-1:0] term_p_r, term_t_r;
  logic signed [ACC_W-1:0] acc_p_r [3];
  logic signed [ACC_W-1:0] acc_t_r [3];

  logic [ACC_W-1:0]   dv_mag_r [6];
  logic [CW-1:0]      dv_rem_r [6];
  logic               dv_neg_r [6];
  logic [DC_W-1:0]    dv_cnt_r;
  logic signed [31:0] res_r [6];

  out_item_t          out_r;
  logic               out_valid_r;

  // write decode
  logic               is_op;
  logic               mat_we, slot_op_we, hdr_op_we, hdr_clr_we;
  logic [MA_W-1:0]    mat_wa;
  logic [SA_W-1:0]    slot_wa;
  slot_ent_t          slot_wd;
  logic [GW-1:0]      hdr_wa;
  hdr_ent_t           hdr_wd;

  always_comb begin
    is_op      = cmd.accept;
    mat_we     = is_op && in_item.operation == OP_MAT && 32'(in_item.index) < MAX_BONES
                 && 32'(in_item.element) < MAT_WORDS;
    mat_wa     = MA_W'(32'(in_item.index) * MAT_WORDS + 32'(in_item.element));
    slot_op_we = is_op && in_item.operation == OP_SLOT && 32'(in_item.index) < MAX_GROUPS
                 && 32'(in_item.element) < SLOTS_PER_GROUP;
    hdr_op_we  = is_op && in_item.operation == OP_HDR && 32'(in_item.index) < MAX_GROUPS;
    hdr_clr_we = cmd.clr_step && ({1'b0, clr_cnt_r} < (SA_W + 1)'(MAX_GROUPS));
    if (cmd.clr_step) begin
      slot_wa = clr_cnt_r;
      slot_wd = '0;
      hdr_wa  = GW'(clr_cnt_r);
      hdr_wd  = '0;
    end else begin
      slot_wa        = SA_W'(32'(in_item.index) * SLOTS_PER_GROUP + 32'(in_item.element));
      slot_wd.filled = in_item.flag && !in_item.value[31] && (in_item.value < MAX_BONES);
      slot_wd.bone   = slot_wd.filled ? in_item.value[BW-1:0] : '0;
      hdr_wa         = GW'(in_item.index);
      hdr_wd.present = in_item.flag;
      if (in_item.value[31]) hdr_wd.count = '0;
      else if (in_item.value > SLOTS_PER_GROUP) hdr_wd.count = CW'(SLOTS_PER_GROUP);
      else hdr_wd.count = in_item.value[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mat_we) mat_mem[mat_wa] <= in_item.value;
    if (cmd.mat_rd) mat_q <= mat_mem[MA_W'(32'(slot_q.bone) * MAT_WORDS + 32'(e_r))];
  end

  always_ff @(posedge clk) begin
    if (slot_op_we || cmd.clr_step) slot_mem[slot_wa] <= slot_wd;
    if (cmd.slot_rd) slot_q <= slot_mem[SA_W'(32'(grp_r) * SLOTS_PER_GROUP + 32'(j_r))];
  end

  always_ff @(posedge clk) begin
    if (hdr_op_we || hdr_clr_we) hdr_mem[hdr_wa] <= hdr_wd;
    if (is_op && in_item.operation == OP_SKIN) hdr_q <= hdr_mem[GW'(in_item.index)];
  end

  // item capture and loop counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (is_op) begin
      grp_r    <= GW'(in_item.index);
      grp_ok_r <= 32'(in_item.index) < MAX_GROUPS;
      j_r      <= '0;
      pos_r[0] <= in_item.pos_x;
      pos_r[1] <= in_item.pos_y;
      pos_r[2] <= in_item.pos_z;
      nrm_r[0] <= in_item.nrm_x;
      nrm_r[1] <= in_item.nrm_y;
      nrm_r[2] <= in_item.nrm_z;
      tgt_r[0] <= sat33(33'(in_item.pos_x) + 33'(in_item.nrm_x));
      tgt_r[1] <= sat33(33'(in_item.pos_y) + 33'(in_item.nrm_y));
      tgt_r[2] <= sat33(33'(in_item.pos_z) + 33'(in_item.nrm_z));
    end else if (cmd.slot_next) begin
      j_r <= j_r + 1'b1;
    end
    if (cmd.slot_rd) begin
      e_r   <= '0;
      row_r <= '0;
      col_r <= '0;
    end else if (cmd.mat_rd) begin
      e_r <= e_r + 4'd1;
      if (col_r == 2'd2) begin
        col_r <= '0;
        row_r <= row_r + 2'd1;
      end else begin
        col_r <= col_r + 2'd1;
      end
    end
  end

  // multiply stage: translation row adds the element as it is
  logic signed [31:0] vp_sel, vt_sel;
  logic signed [63:0] prod_p, prod_t;

  always_comb begin
    unique case (s1_row_r)
      2'd0:    begin vp_sel = pos_r[0]; vt_sel = tgt_r[0]; end
      2'd1:    begin vp_sel = pos_r[1]; vt_sel = tgt_r[1]; end
      default: begin vp_sel = pos_r[2]; vt_sel = tgt_r[2]; end
    endcase
    prod_p = 64'(vp_sel) * 64'(mat_q);
    prod_t = 64'(vt_sel) * 64'(mat_q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.mat_rd;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_row_r <= row_r;
    s1_col_r <= col_r;
    s2_col_r <= s1_col_r;
    if (s1_v_r) begin
      if (s1_row_r == 2'd3) begin
        term_p_r <= ACC_W'(mat_q);
        term_t_r <= ACC_W'(mat_q);
      end else begin
        term_p_r <= ACC_W'(prod_p >>> FRAC_BITS);
        term_t_r <= ACC_W'(prod_t >>> FRAC_BITS);
      end
    end
    if (is_op) begin
      for (int k = 0; k < 3; k++) begin
        acc_p_r[k] <= '0;
        acc_t_r[k] <= '0;
      end
    end else if (s2_v_r) begin
      acc_p_r[s2_col_r] <= acc_p_r[s2_col_r] + term_p_r;
      acc_t_r[s2_col_r] <= acc_t_r[s2_col_r] + term_t_r;
    end
  end

  // restoring division by the slot count, one quotient bit per cycle in six lanes
  logic signed [ACC_W-1:0] dv_src [6];
  logic [CW:0]             dv_tmp [6];
  logic signed [ACC_W:0]   dv_q   [6];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dv_src[k]     = acc_p_r[k];
      dv_src[k + 3] = acc_t_r[k];
    end
    for (int k = 0; k < 6; k++) begin
      dv_tmp[k] = {dv_rem_r[k], dv_mag_r[k][ACC_W-1]};
      dv_q[k]   = dv_neg_r[k] ? -$signed({1'b0, dv_mag_r[k]}) : $signed({1'b0, dv_mag_r[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dv_cnt_r <= '0;
      for (int k = 0; k < 6; k++) begin
        dv_neg_r[k] <= dv_src[k][ACC_W-1];
        dv_mag_r[k] <= dv_src[k][ACC_W-1] ? ACC_W'(-dv_src[k]) : dv_src[k];
        dv_rem_r[k] <= '0;
      end
    end else if (cmd.div_step) begin
      dv_cnt_r <= dv_cnt_r + 1'b1;
      for (int k = 0; k < 6; k++) begin
        if (dv_tmp[k] >= {1'b0, hdr_q.count}) begin
          dv_rem_r[k] <= CW'(dv_tmp[k] - {1'b0, hdr_q.count});
          dv_mag_r[k] <= {dv_mag_r[k][ACC_W-2:0], 1'b1};
        end else begin
          dv_rem_r[k] <= dv_tmp[k][CW-1:0];
          dv_mag_r[k] <= {dv_mag_r[k][ACC_W-2:0], 1'b0};
        end
      end
    end
    if (cmd.div_fin) begin
      for (int k = 0; k < 6; k++) res_r[k] <= sat_acc(dv_q[k]);
    end
  end

  // result register
  logic absent;
  assign absent = !grp_ok_r || !hdr_q.present;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (absent) begin
        out_r.out_pos_x <= pos_r[0];
        out_r.out_pos_y <= pos_r[1];
        out_r.out_pos_z <= pos_r[2];
        out_r.out_nrm_x <= nrm_r[0];
        out_r.out_nrm_y <= nrm_r[1];
        out_r.out_nrm_z <= nrm_r[2];
        out_r.status    <= 1'b1;
      end else if (hdr_q.count == '0) begin
        out_r <= '0;
      end else begin
        out_r.out_pos_x <= res_r[0];
        out_r.out_pos_y <= res_r[1];
        out_r.out_pos_z <= res_r[2];
        out_r.out_nrm_x <= sat33(33'(res_r[3]) - 33'(res_r[0]));
        out_r.out_nrm_y <= sat33(33'(res_r[4]) - 33'(res_r[1]));
        out_r.out_nrm_z <= sat33(33'(res_r[5]) - 33'(res_r[2]));
        out_r.status    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= cmd.out_load;
  end

  assign out_item  = out_r;
  assign out_valid = out_valid_r;

  always_comb begin
    sts.clr_last    = (clr_cnt_r == SA_W'(SLOT_DEPTH - 1));
    sts.pass        = absent || (hdr_q.count == '0);
    sts.slot_more   = (j_r < hdr_q.count);
    sts.slot_filled = slot_q.filled;
    sts.mat_last    = (e_r == 4'(MAT_WORDS - 1));
    sts.div_done    = (dv_cnt_r == DC_W'(ACC_W));
  end

endmodule
`default_nettype wire

/* src/vertex_bone_skinning.sv */
// Vertex bone skinning, top level. After reset the block clears its group tables
// with busy high. Load transactions (matrix element, group slot, group header)
// are taken while idle and do not make the block busy. A skin transaction's
// duration is set by the bit-serial divide by the slot count and by the single
// matrix memory read port, which reads one element at a time; absent groups or
// a zero count skip the slot loop and the divide. Each result is shown for one
// cycle with out_valid and cannot be stalled, so the receiver must take it then.
`timescale 1ns / 1ps
`default_nettype none
module vertex_bone_skinning #(
  parameter int MAX_BONES       = vbs_pkg::MAX_BONES_DEF,
  parameter int MAX_GROUPS      = vbs_pkg::MAX_GROUPS_DEF,
  parameter int SLOTS_PER_GROUP = vbs_pkg::SLOTS_PER_GROUP_DEF,
  parameter int FRAC_BITS       = vbs_pkg::FRAC_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  vbs_pkg::in_item_t   in_item,
  output logic                out_valid,
  output vbs_pkg::out_item_t  out_item
);
  import vbs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  vbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .operation (in_item.operation),
    .busy      (busy),
    .cmd       (cmd),
    .sts       (sts)
  );

  vbs_dp #(
    .MAX_BONES       (MAX_BONES),
    .MAX_GROUPS      (MAX_GROUPS),
    .SLOTS_PER_GROUP (SLOTS_PER_GROUP),
    .FRAC_BITS       (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_item),
    .out_valid (out_valid)
  );

  // a result strobe never lasts more than one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // a skin transaction keeps the block busy in the next cycle
  a_skin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.operation == OP_SKIN) |=> busy)
    else $error("skin transaction did not start work");

  // load transactions never produce a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.operation != OP_SKIN) |=> !out_valid)
    else $error("load transaction produced a result");

  // a result only appears while the block has finished its work
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

endmodule
`default_nettype wire
